// ===== rtl/integer_to_ascii_radix_formatter_macros.svh =====
// Assertion helpers for the formatter RTL.
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define I2A_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define I2A_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/i2a_pkg.sv =====
package i2a_pkg;

   // Number of low bits of the input value that are formatted.
   localparam int VALUE_WIDTH = 64;

   // Digit counts of the widest value in each base.
   localparam int NDIG_BIN = VALUE_WIDTH;
   localparam int NDIG_OCT = (VALUE_WIDTH + 2) / 3;
   localparam int NDIG_DEC = (VALUE_WIDTH * 30103 + 99999) / 100000;
   localparam int NDIG_HEX = (VALUE_WIDTH + 3) / 4;

   // Bit widths of the left-aligned digit strings.
   localparam int OCT_W = 3 * NDIG_OCT;
   localparam int BCD_W = 4 * NDIG_DEC;
   localparam int HEX_W = 4 * NDIG_HEX;
   localparam int WORK_W0 = (OCT_W > VALUE_WIDTH) ? OCT_W : VALUE_WIDTH;
   localparam int WORK_W = (BCD_W > WORK_W0) ? BCD_W : WORK_W0;

   // Left shifts that place the most significant digit at the top of the work register.
   localparam int SH_BIN = WORK_W - VALUE_WIDTH;
   localparam int SH_OCT = WORK_W - OCT_W;
   localparam int SH_DEC = WORK_W - BCD_W;
   localparam int SH_HEX = WORK_W - HEX_W;

   // The count register holds step and digit counts up to the binary digit count.
   localparam int CNT_W = $clog2(NDIG_BIN + 1);

   localparam logic [6:0] CHAR_ZERO = 7'h30;
   localparam logic [6:0] CHAR_A_LESS_TEN = 7'h57;
   localparam logic [3:0] DIGIT_TEN = 4'd10;

   typedef enum logic [1:0] {
      MODE_BIN,
      MODE_OCT,
      MODE_DEC,
      MODE_HEX
   } mode_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_DABBLE,
      OP_DABBLE_LAST,
      OP_SHIFT
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_EMIT
   } state_type;

   // Command from the sequencer to the datapath.
   typedef struct packed {
      op_type   op;
      mode_type mode;
   } dp_ctrl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic top_zero;
      logic top_valid;
   } dp_stat_type;

   // ASCII code of one digit, lowercase letters above nine.
   function automatic logic [6:0] char_of_digit(input logic [3:0] digit);
      logic [6:0] code;
      if (digit < DIGIT_TEN) begin
         code = CHAR_ZERO + {3'b000, digit};
      end else begin
         code = CHAR_A_LESS_TEN + {3'b000, digit};
      end
      return code;
   endfunction

   // Number of digit positions of the aligned string in each base.
   function automatic logic [CNT_W-1:0] ndig_of_mode(input mode_type mode);
      logic [CNT_W-1:0] n;
      unique case (mode)
         MODE_BIN: n = CNT_W'(NDIG_BIN);
         MODE_OCT: n = CNT_W'(NDIG_OCT);
         MODE_DEC: n = CNT_W'(NDIG_DEC);
         MODE_HEX: n = CNT_W'(NDIG_HEX);
         default:  n = CNT_W'(NDIG_HEX);
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/i2a_datapath.sv =====
module i2a_datapath
   import i2a_pkg::*;
(
   input  logic                   clock,
   input  dp_ctrl_type            ctrl,
   input  logic [VALUE_WIDTH-1:0] value,
   output dp_stat_type            stat,
   output logic [6:0]             char_code
);

   logic [VALUE_WIDTH-1:0] bin_ff;
   logic [VALUE_WIDTH-1:0] bin_in;
   logic [WORK_W-1:0]      work_ff;
   logic [WORK_W-1:0]      work_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [BCD_W-1:0]       bcd_next;
   logic [WORK_W-1:0]      load_word;
   logic [WORK_W-1:0]      shifted;
   logic [3:0]             top_digit;

   // Add-three correction on every BCD digit ahead of the shift.
   always_comb begin
      for (int i = 0; i < NDIG_DEC; i++) begin
         if (work_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = work_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = work_ff[4*i +: 4];
         end
      end
      bcd_next = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
   end

   // Aligned load word, top digit and one-digit shift for the selected base.
   always_comb begin
      unique case (ctrl.mode)
         MODE_BIN: begin
            load_word = WORK_W'(value) << SH_BIN;
            top_digit = {3'b000, work_ff[WORK_W-1]};
            shifted   = work_ff << 1;
         end
         MODE_OCT: begin
            load_word = WORK_W'(value) << SH_OCT;
            top_digit = {1'b0, work_ff[WORK_W-1 -: 3]};
            shifted   = work_ff << 3;
         end
         MODE_DEC: begin
            load_word = '0;
            top_digit = work_ff[WORK_W-1 -: 4];
            shifted   = work_ff << 4;
         end
         MODE_HEX: begin
            load_word = WORK_W'(value) << SH_HEX;
            top_digit = work_ff[WORK_W-1 -: 4];
            shifted   = work_ff << 4;
         end
         default: begin
            load_word = '0;
            top_digit = '0;
            shifted   = work_ff;
         end
      endcase
   end

   // Next value of the shared shift register pair.
   always_comb begin
      bin_in  = bin_ff;
      work_in = work_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         OP_LOAD: begin
            bin_in  = value;
            work_in = load_word;
         end
         OP_DABBLE: begin
            bin_in  = bin_ff << 1;
            work_in = WORK_W'(bcd_next);
         end
         OP_DABBLE_LAST: begin
            bin_in  = bin_ff << 1;
            work_in = WORK_W'(bcd_next) << SH_DEC;
         end
         OP_SHIFT: begin
            work_in = shifted;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      work_ff <= work_in;
   end

   assign stat.top_zero  = (top_digit == 4'd0);
   assign stat.top_valid = (top_digit < DIGIT_TEN) || (ctrl.mode == MODE_HEX);
   assign char_code      = char_of_digit(top_digit);

endmodule

// ===== rtl/i2a_sequencer.sv =====
module i2a_sequencer
   import i2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_mode,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl,
   output logic        req_stall,
   output logic        rsp_valid,
   output logic        rsp_last
);

   state_type        state_ff;
   state_type        state_in;
   mode_type         mode_ff;
   mode_type         mode_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   // State, base and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mode_ff <= mode_in;
   end

   // Next state and datapath command.
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      ctrl.op   = OP_HOLD;
      ctrl.mode = mode_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ctrl.mode = mode_type'(req_mode);
            if (req_valid) begin
               ctrl.op = OP_LOAD;
               mode_in = mode_type'(req_mode);
               if (mode_type'(req_mode) == MODE_DEC) begin
                  cnt_in   = CNT_W'(VALUE_WIDTH - 1);
                  state_in = ST_CONVERT;
               end else begin
                  cnt_in   = ndig_of_mode(mode_type'(req_mode));
                  state_in = ST_STRIP;
               end
            end
         end
         ST_CONVERT: begin
            // One binary bit enters the BCD string per cycle.
            if (cnt_ff == '0) begin
               ctrl.op  = OP_DABBLE_LAST;
               cnt_in   = CNT_W'(NDIG_DEC);
               state_in = ST_STRIP;
            end else begin
               ctrl.op = OP_DABBLE;
               cnt_in  = cnt_ff - CNT_W'(1);
            end
         end
         ST_STRIP: begin
            // Drop leading zeros, keeping at least one digit.
            if (stat.top_zero && (cnt_ff > CNT_W'(1))) begin
               ctrl.op = OP_SHIFT;
               cnt_in  = cnt_ff - CNT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            rsp_last  = (cnt_ff == CNT_W'(1));
            if (!rsp_stall) begin
               ctrl.op = OP_SHIFT;
               cnt_in  = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/integer_to_ascii_radix_formatter.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_value[63:0], req_mode[1:0]
// rsp_      out        rsp_valid/rsp_stall  rsp_char_code[6:0], rsp_last
//
// One transaction at a time: req_stall is high from acceptance until the last character
// has been taken. Decimal requests first run the BCD shift-and-adjust loop, one bit a
// cycle; then every base skips leading zero digits, keeping at least one, and sends the
// characters, most significant first.
// Reset is synchronous and active high and returns the sequencer to idle.
// A stalled character holds its code and last flag.
`include "integer_to_ascii_radix_formatter_macros.svh"

module integer_to_ascii_radix_formatter
   import i2a_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_char_code,
   output logic        rsp_last
);

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   // Sequencer steering the shared shift unit.
   i2a_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctrl      (ctrl),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_last)
   );

   // Value, BCD and digit shift registers.
   i2a_datapath u_dp (
      .clock     (clock),
      .ctrl      (ctrl),
      .value     (req_value[VALUE_WIDTH-1:0]),
      .stat      (stat),
      .char_code (rsp_char_code)
   );

   // Consistency checks on the sequencing.
   `I2A_ASSERT(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "no stall after accept")
   `I2A_ASSERT(a_no_accept_while_emit, rsp_valid |-> req_stall, "input open during output")
   `I2A_ASSERT(a_idle_after_last, (rsp_valid && !rsp_stall && rsp_last) |=> !rsp_valid, "output after last")
   `I2A_ASSERT(a_digit_in_base, rsp_valid |-> stat.top_valid, "digit out of range for base")
   `I2A_ASSERT_ALWAYS(a_reset_idle, reset |=> (!rsp_valid && !req_stall), "not idle after reset")

endmodule
